/* sv/ppf_pkg.sv */
// Shared types and constants for the pair product finder.
// No dependencies; every other file of the block refers to this package by scoped names.
package ppf_pkg;

    // Width of the target product register and of the dividend.
    localparam int TARGET_BITS = 64;
    // Width of the value field on the input channel.
    localparam int IN_VALUE_BITS = 32;

    // Token that walks down the cell chain during a set lookup.
    typedef struct packed {
        logic valid;
        logic hit_q;   // quotient key seen so far
        logic hit_v;   // incoming value key seen so far
    } t_token;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_INJECT,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } t_state;

endpackage

/* sv/ppf_if.sv */
// Streaming channel interfaces of the pair product finder.
// Depends on ppf_pkg for the field widths.
interface ppf_in_if;
    logic                                valid;
    logic                                ready;
    logic [ppf_pkg::IN_VALUE_BITS-1:0]   value;
    logic                                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface ppf_out_if;
    logic valid;
    logic ready;
    logic found;
    logic overflow;

    modport source (output valid, output found, output overflow, input ready);
    modport sink   (input valid, input found, input overflow, output ready);
endinterface

/* sv/ppf_cell.sv */
// One cell of the value set: holds one stored value and passes the lookup token on.
// Depends on ppf_pkg for the token type.
module ppf_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [VALUE_BITS-1:0] i_key_q,
    input  logic [VALUE_BITS-1:0] i_key_v,
    input  logic                  i_inject,
    input  logic                  i_wr_en,
    input  ppf_pkg::t_token       i_tok,
    output ppf_pkg::t_token       o_tok
);

    logic [VALUE_BITS-1:0] r_value;
    ppf_pkg::t_token       r_tok;
    ppf_pkg::t_token       w_tok_in;

    always_comb begin
        if (i_inject) begin
            w_tok_in = '{valid: 1'b1, hit_q: 1'b0, hit_v: 1'b0};
        end else begin
            w_tok_in = i_tok;
        end
    end

    // The new value is broadcast on the value key bus at insertion time.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_value <= i_key_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.valid <= w_tok_in.valid;
            r_tok.hit_q <= w_tok_in.valid && (w_tok_in.hit_q || (r_value == i_key_q));
            r_tok.hit_v <= w_tok_in.valid && (w_tok_in.hit_v || (r_value == i_key_v));
        end
    end

    assign o_tok = r_tok;

endmodule

/* sv/ppf_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle, for target / value magnitudes.
// Depends on ppf_pkg for the dividend width.
module ppf_divider #(
    parameter int DIVISOR_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ppf_pkg::TARGET_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]         i_divisor,
    output logic                            o_done,
    output logic [ppf_pkg::TARGET_BITS-1:0] o_quot,
    output logic                            o_rem_zero
);

    localparam int TB    = ppf_pkg::TARGET_BITS;
    localparam int CNT_W = $clog2(TB + 1);

    logic [TB-1:0]           r_work;
    logic [DIVISOR_BITS-1:0] r_rem;
    logic [DIVISOR_BITS-1:0] r_divisor;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_done;
    logic [DIVISOR_BITS:0]   w_rem_sh;
    logic [DIVISOR_BITS:0]   w_diff;
    logic                    w_ge;

    // The partial remainder always stays below the divisor, so it fits its width.
    assign w_rem_sh = {r_rem, r_work[TB-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_divisor};
    assign w_diff   = w_rem_sh - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(TB);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_cnt != '0) begin
            r_work <= {r_work[TB-2:0], w_ge};
            if (w_ge) begin
                r_rem <= w_diff[DIVISOR_BITS-1:0];
            end else begin
                r_rem <= w_rem_sh[DIVISOR_BITS-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quot     = r_work;
    assign o_rem_zero = (r_rem == '0);

endmodule

/* sv/pair_product_finder_top.sv */
// Pair product finder: top level with control sequencer and the chain of set cells.
// Depends on ppf_pkg, the interfaces in ppf_if.sv, ppf_cell and ppf_divider.
//
// Usage: values arrive on i_in (valid/ready, value, last); one transaction per value.
// For each value the block asks whether an earlier value of the same sequence times it
// equals the target written through i_cfg_wr_en / i_cfg_wr_data. On a transaction with
// last set, one result transaction (found, overflow) is offered on o_out, and the stored
// set and both flags are cleared for the next sequence.
// Steps per value: the input is accepted, the bit-serial divider runs (skipped for a zero
// value), the lookup token is injected and walks through the values stored so far
// (injection and walk are skipped while the set is empty), and a decision step follows.
// A value that arrives after a match has been found is only accepted and dropped.
// The last value adds a step that loads the output register.
// The input is accepted only between values; one value is in work at a time.
// The output is registered: a waiting result does not hold up the next values, and only
// a further last value waits until the receiver has taken the earlier result.
// Reset (synchronous, active low) clears the target to zero, empties the set and drops
// any pending result; the set needs no clearing pass.
module pair_product_finder_top #(
    parameter int SET_ENTRIES = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ppf_in_if.sink                          i_in,
    ppf_out_if.source                       o_out,
    input  logic                            i_cfg_wr_en,
    input  logic [ppf_pkg::TARGET_BITS-1:0] i_cfg_wr_data
);

    localparam int TB    = ppf_pkg::TARGET_BITS;
    localparam int IDX_W = $clog2(SET_ENTRIES);
    localparam int CNT_W = $clog2(SET_ENTRIES + 1);
    localparam logic [TB-1:0] Q_LIMIT = TB'(1) << (VALUE_BITS - 1);

    ppf_pkg::t_state       r_state, n_state;
    logic [TB-1:0]         r_target;
    logic [VALUE_BITS-1:0] r_v;
    logic                  r_last;
    logic [VALUE_BITS-1:0] r_key_q;
    logic                  r_q_ok;
    logic                  r_hit_q;
    logic                  r_hit_v;
    logic [CNT_W-1:0]      r_count;
    logic                  r_found;
    logic                  r_ovf;
    logic                  r_out_valid;
    logic                  r_out_found;
    logic                  r_out_ovf;

    logic                  w_in_ready;
    logic                  w_accept;
    logic                  w_div_start;
    logic                  w_inject;
    logic                  w_load_out;
    logic                  w_wr_go;
    logic                  w_match;
    logic                  w_set_empty;

    logic [VALUE_BITS-1:0] w_v_in;
    logic                  w_v_in_zero;
    logic [VALUE_BITS-1:0] w_v_mag;
    logic [TB-1:0]         w_t_mag;

    logic                  w_div_done;
    logic [TB-1:0]         w_quot;
    logic                  w_rem_zero;
    logic                  w_q_neg;
    logic                  w_q_ok;
    logic [VALUE_BITS-1:0] w_pattern;

    logic [IDX_W-1:0]      w_last_idx;
    ppf_pkg::t_token       w_tok [SET_ENTRIES];

    // Divider operand magnitudes: the value from the input, the target from r_target.
    assign w_v_in      = i_in.value[VALUE_BITS-1:0];
    assign w_v_in_zero = (w_v_in == '0);
    assign w_v_mag     = w_v_in[VALUE_BITS-1] ? (~w_v_in + VALUE_BITS'(1)) : w_v_in;
    assign w_t_mag     = r_target[TB-1] ? (~r_target + TB'(1)) : r_target;

    ppf_divider #(
        .DIVISOR_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_t_mag),
        .i_divisor  (w_v_mag),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem_zero (w_rem_zero)
    );

    // A quotient that does not fit a signed value of the set cannot be in it.
    assign w_q_neg   = (r_target[TB-1] ^ r_v[VALUE_BITS-1]) && (w_quot != '0);
    assign w_q_ok    = w_rem_zero && (w_q_neg ? (w_quot <= Q_LIMIT) : (w_quot < Q_LIMIT));
    assign w_pattern = w_q_neg ? (~w_quot[VALUE_BITS-1:0] + VALUE_BITS'(1))
                               : w_quot[VALUE_BITS-1:0];

    assign w_set_empty = (r_count == '0);
    assign w_last_idx  = IDX_W'(r_count - CNT_W'(1));
    assign w_match     = r_q_ok && r_hit_q;
    assign w_accept    = i_in.valid && w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_inject    = 1'b0;
        w_load_out  = 1'b0;
        w_wr_go     = 1'b0;
        case (r_state)
            ppf_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    if (r_found) begin
                        n_state = i_in.last ? ppf_pkg::ST_EMIT : ppf_pkg::ST_IDLE;
                    end else if (w_v_in_zero) begin
                        n_state = w_set_empty ? ppf_pkg::ST_DECIDE : ppf_pkg::ST_INJECT;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = ppf_pkg::ST_DIVIDE;
                    end
                end
            end
            ppf_pkg::ST_DIVIDE: begin
                if (w_div_done) begin
                    n_state = w_set_empty ? ppf_pkg::ST_DECIDE : ppf_pkg::ST_INJECT;
                end
            end
            ppf_pkg::ST_INJECT: begin
                w_inject = 1'b1;
                n_state  = ppf_pkg::ST_SCAN;
            end
            ppf_pkg::ST_SCAN: begin
                if (w_tok[0].valid) begin
                    n_state = ppf_pkg::ST_DECIDE;
                end
            end
            ppf_pkg::ST_DECIDE: begin
                w_wr_go = !w_match && !r_hit_v && (r_count < CNT_W'(SET_ENTRIES));
                n_state = r_last ? ppf_pkg::ST_EMIT : ppf_pkg::ST_IDLE;
            end
            ppf_pkg::ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ppf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ppf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state of the running sequence and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (r_state == ppf_pkg::ST_DECIDE) begin
                if (w_match) begin
                    r_found <= 1'b1;
                end else if (!r_hit_v) begin
                    if (w_wr_go) begin
                        r_count <= r_count + CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_found     <= 1'b0;
                r_ovf       <= 1'b0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the value in progress.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_v     <= w_v_in;
            r_last  <= i_in.last;
            r_hit_q <= 1'b0;
            r_hit_v <= 1'b0;
            r_key_q <= '0;
            r_q_ok  <= (r_target == '0);
        end
        if ((r_state == ppf_pkg::ST_DIVIDE) && w_div_done) begin
            r_key_q <= w_pattern;
            r_q_ok  <= w_q_ok;
        end
        if ((r_state == ppf_pkg::ST_SCAN) && w_tok[0].valid) begin
            r_hit_q <= w_tok[0].hit_q;
            r_hit_v <= w_tok[0].hit_v;
        end
        if (w_load_out) begin
            r_out_found <= r_found;
            r_out_ovf   <= r_ovf;
        end
    end

    // The token enters at the newest stored value and walks down to cell 0.
    for (genvar i = 0; i < SET_ENTRIES; i++) begin : g_cell
        ppf_pkg::t_token w_tok_in;
        logic            w_cell_wr;
        logic            w_cell_inject;

        if (i == SET_ENTRIES - 1) begin : g_tail
            assign w_tok_in = '0;
        end else begin : g_link
            assign w_tok_in = w_tok[i+1];
        end

        assign w_cell_wr     = w_wr_go && (r_count[IDX_W-1:0] == IDX_W'(i));
        assign w_cell_inject = w_inject && (w_last_idx == IDX_W'(i));

        ppf_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_key_q  (r_key_q),
            .i_key_v  (r_v),
            .i_inject (w_cell_inject),
            .i_wr_en  (w_cell_wr),
            .i_tok    (w_tok_in),
            .o_tok    (w_tok[i])
        );
    end

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_out_found;
    assign o_out.overflow = r_out_ovf;

endmodule
